### sv/mrhp_pkg.sv
// Shared types and codes for the read holding registers response parser.
// No dependencies; imported by mrhp_core and the top-level unit.
package mrhp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned ERR_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [BYTE_W-1:0] FC_READ_HOLDING = 8'h03;
	localparam logic [BYTE_W-1:0] EXC_FLAG        = 8'h80;

	typedef enum logic [KIND_W-1:0] {
		EV_START = 3'd0,
		EV_VALUE = 3'd1,
		EV_END   = 3'd2,
		EV_EXC   = 3'd3,
		EV_ERROR = 3'd4
	} ev_kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_SLAVE = 2'd0,
		ERR_FUNC  = 2'd1,
		ERR_TRUNC = 2'd2,
		ERR_COUNT = 2'd3
	} err_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPECTED_SLAVE = 2'd0,
		CFG_START_ADDRESS  = 2'd1,
		CFG_REGISTER_COUNT = 2'd2
	} cfg_index_t;

	typedef enum logic [5:0] {
		PH_ADDR  = 6'b000001,
		PH_FUNC  = 6'b000010,
		PH_COUNT = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_EXC   = 6'b010000,
		PH_SKIP  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]  event_kind;
		logic [ADDR_W-1:0]  reg_address;
		logic [VALUE_W-1:0] reg_value;
		logic [BYTE_W-1:0]  exception_code;
		logic [ERR_W-1:0]   error_code;
		logic               run_last;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  expected_slave;
		logic [ADDR_W-1:0]  start_address;
		logic [COUNT_W-1:0] register_count;
	} cfg_t;

endpackage

### sv/mrhp_core.sv
// Frame parsing state machine: consumes one byte per step and produces up to two results.
// Depends on mrhp_pkg.
module mrhp_core #(
	parameter int unsigned MAX_REGISTERS = 125
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               frame_byte,
	input  logic                     last_byte,
	input  mrhp_pkg::cfg_t           cfg,
	output logic [1:0]               n_results,
	output mrhp_pkg::result_t        res0,
	output mrhp_pkg::result_t        res1
);
	import mrhp_pkg::*;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_REGISTERS);

	phase_t              phase_q, phase_d;
	logic [ADDR_W-1:0]   cur_addr_q, cur_addr_d;
	logic [COUNT_W-1:0]  remaining_q, remaining_d;
	logic [BYTE_W-1:0]   high_hold_q, high_hold_d;
	logic                high_valid_q, high_valid_d;
	logic [COUNT_W-1:0]  rem_dec;
	logic [BYTE_W-1:0]   count_expected;
	logic                count_ok;

	function automatic result_t mk(input ev_kind_t kind, input err_code_t err);
		result_t r;
		r = '0;
		r.event_kind = kind;
		r.error_code = err;
		return r;
	endfunction

	assign rem_dec        = remaining_q - COUNT_W'(1);
	assign count_expected = {cfg.register_count, 1'b0};
	assign count_ok       = (cfg.register_count != '0) && (cfg.register_count <= MAX_COUNT)
		&& (frame_byte == count_expected);

	always_comb begin
		phase_d      = phase_q;
		cur_addr_d   = cur_addr_q;
		remaining_d  = remaining_q;
		high_hold_d  = high_hold_q;
		high_valid_d = high_valid_q;
		n_results    = 2'd0;
		res0         = '0;
		res1         = '0;
		unique case (phase_q)
			PH_ADDR: begin
				if (frame_byte != cfg.expected_slave) begin
					n_results = 2'd1;
					res0 = mk(EV_ERROR, ERR_SLAVE);
					phase_d = last_byte ? PH_ADDR : PH_SKIP;
					high_valid_d = 1'b0;
				end else if (last_byte) begin
					n_results = 2'd1;
					res0 = mk(EV_ERROR, ERR_TRUNC);
					phase_d = PH_ADDR;
					high_valid_d = 1'b0;
				end else begin
					phase_d = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (frame_byte == FC_READ_HOLDING || frame_byte == (FC_READ_HOLDING | EXC_FLAG)) begin
					if (last_byte) begin
						n_results = 2'd1;
						res0 = mk(EV_ERROR, ERR_TRUNC);
						phase_d = PH_ADDR;
						high_valid_d = 1'b0;
					end else begin
						phase_d = (frame_byte == FC_READ_HOLDING) ? PH_COUNT : PH_EXC;
					end
				end else begin
					n_results = 2'd1;
					res0 = mk(EV_ERROR, ERR_FUNC);
					phase_d = last_byte ? PH_ADDR : PH_SKIP;
					high_valid_d = 1'b0;
				end
			end
			PH_COUNT: begin
				if (!count_ok) begin
					n_results = 2'd1;
					res0 = mk(EV_ERROR, ERR_COUNT);
					phase_d = last_byte ? PH_ADDR : PH_SKIP;
					high_valid_d = 1'b0;
				end else begin
					n_results = 2'd1;
					res0 = mk(EV_START, ERR_SLAVE);
					cur_addr_d = cfg.start_address;
					remaining_d = cfg.register_count;
					high_valid_d = 1'b0;
					high_hold_d = '0;
					if (last_byte) begin
						n_results = 2'd2;
						res1 = mk(EV_ERROR, ERR_TRUNC);
						phase_d = PH_ADDR;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (!high_valid_q) begin
					high_hold_d = frame_byte;
					high_valid_d = 1'b1;
					if (last_byte) begin
						n_results = 2'd1;
						res0 = mk(EV_ERROR, ERR_TRUNC);
						phase_d = PH_ADDR;
						high_valid_d = 1'b0;
					end
				end else begin
					res0 = mk(EV_VALUE, ERR_SLAVE);
					res0.reg_address = cur_addr_q;
					res0.reg_value = {high_hold_q, frame_byte};
					cur_addr_d = cur_addr_q + ADDR_W'(1);
					remaining_d = rem_dec;
					high_valid_d = 1'b0;
					n_results = 2'd1;
					if (rem_dec == '0) begin
						n_results = 2'd2;
						res1 = mk(EV_END, ERR_SLAVE);
						phase_d = last_byte ? PH_ADDR : PH_SKIP;
					end else if (last_byte) begin
						n_results = 2'd2;
						res1 = mk(EV_ERROR, ERR_TRUNC);
						phase_d = PH_ADDR;
					end
				end
			end
			PH_EXC: begin
				n_results = 2'd1;
				res0 = mk(EV_EXC, ERR_SLAVE);
				res0.exception_code = frame_byte;
				phase_d = last_byte ? PH_ADDR : PH_SKIP;
				high_valid_d = 1'b0;
			end
			default: begin
				// Skip phase: discard bytes up to the end of the frame.
				if (last_byte) begin
					phase_d = PH_ADDR;
				end
			end
		endcase
		if (n_results == 2'd1) begin
			res0.run_last = 1'b1;
		end
		if (n_results == 2'd2) begin
			res1.run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_ADDR;
			cur_addr_q   <= '0;
			remaining_q  <= '0;
			high_valid_q <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			cur_addr_q   <= cur_addr_d;
			remaining_q  <= remaining_d;
			high_valid_q <= high_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			high_hold_q <= high_hold_d;
		end
	end

	// A register count check that passes implies the count is in range and nonzero.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_COUNT && count_ok |=> remaining_q != '0)
		else $error("register count accepted outside its range");
	a_value_needs_high: assert property (@(posedge clk) disable iff (!arst_n)
		step && res0.event_kind == EV_VALUE && n_results != 2'd0 |-> high_valid_q)
		else $error("value emitted without a held high byte");
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && n_results == 2'd2 && res1.event_kind == EV_END |=> !high_valid_q)
		else $error("high byte still held after end of data");

endmodule

### sv/modbus_read_holding_response_parser_unit.sv
// Top level of the read holding registers response parser: stream ports, configuration
// registers, input register and a two-entry result queue. Depends on mrhp_pkg and mrhp_core.

// The unit takes one response byte per cycle on the slave stream while its result queue has
// room, and reports start, register value, end, exception and error events on the master
// stream, one event per transfer. A byte is registered on acceptance and parsed, once the
// queue has room for its events, into a two-entry result queue whose head is presented on
// the master stream. Most bytes cause at most one event; a byte that causes two events (start
// with truncation, last value with end or truncation) fills the queue, which drains one
// event per cycle while the master stream is ready. Configuration writes are always taken and
// should be made between frames.
module modbus_read_holding_response_parser_unit #(
	parameter int unsigned MAX_REGISTERS = 125
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream: tdata = frame_byte[7:0]; tlast = last_byte.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	// Master stream: tdata = reg_address[15:0], reg_value[31:16], exception_code[39:32],
	// error_code[41:40], zero padding[47:42]; tlast = run_last.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// tuser = event_kind[2:0].
	output logic [2:0]  m_axis_tuser,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mrhp_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;
	result_t            q0_q, q1_q;
	logic [1:0]         cnt_q;
	logic [1:0]         n_results;
	result_t            res0, res1;
	logic               pop;
	logic [1:0]         cnt_left;
	logic [2:0]         cnt_need;
	logic               advance;
	logic               in_xfer;
	result_t            keep0;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_slave <= '0;
			cfg_q.start_address  <= '0;
			cfg_q.register_count <= COUNT_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EXPECTED_SLAVE: cfg_q.expected_slave <= cfg_data[BYTE_W-1:0];
				CFG_START_ADDRESS:  cfg_q.start_address  <= cfg_data[ADDR_W-1:0];
				CFG_REGISTER_COUNT: cfg_q.register_count <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	mrhp_core #(
		.MAX_REGISTERS(MAX_REGISTERS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.frame_byte(byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.n_results (n_results),
		.res0      (res0),
		.res1      (res1)
	);

	assign pop      = m_axis_tvalid && m_axis_tready;
	assign cnt_left = cnt_q - {1'b0, pop};
	assign cnt_need = {1'b0, cnt_left} + {1'b0, n_results};
	assign advance  = valid_s1 && (cnt_need <= 3'd2);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign keep0    = pop ? q1_q : q0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= advance ? cnt_need[1:0] : cnt_left;
		end
	end

	// The queue keeps its head in the first entry; new events go behind what remains.
	always_ff @(posedge clk) begin
		if (advance && cnt_left == 2'd0) begin
			q0_q <= res0;
			q1_q <= res1;
		end else if (advance && cnt_left == 2'd1) begin
			q0_q <= keep0;
			q1_q <= res0;
		end else if (pop) begin
			q0_q <= q1_q;
		end
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata  = {6'd0, q0_q.error_code, q0_q.exception_code, q0_q.reg_value,
		q0_q.reg_address};
	assign m_axis_tlast  = q0_q.run_last;
	assign m_axis_tuser  = q0_q.event_kind;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overfilled");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_END |-> m_axis_tlast)
		else $error("end event not marked as the last of its byte");
	a_exc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_EXC |-> m_axis_tlast)
		else $error("exception event not marked as the last of its byte");
	a_addr_only_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != EV_VALUE |-> m_axis_tdata[31:0] == 32'd0)
		else $error("address or value set on a non-value event");

endmodule

### bench/tb_top.sv
// Self-checking bench for the read holding registers response parser unit.
// Depends on mrhp_pkg and modbus_read_holding_response_parser_unit; drives frames byte by byte
// and checks every event on the master stream against a behavioural parser model kept here.
module tb_top;
	import mrhp_pkg::*;

	localparam int MAX_REGS    = 125;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 60;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	modbus_read_holding_response_parser_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Parser model state and its copy of the configuration registers.
	phase_t       ph;
	logic [15:0]  cur_addr;
	logic [6:0]   regs_left;
	logic [7:0]   high_hold;
	logic         high_valid;
	logic [7:0]   cfg_slave;
	logic [15:0]  cfg_start;
	logic [6:0]   cfg_count;

	result_t      expected_events [$];
	int           mismatches;
	int           events_checked;
	int           parsed_items;
	int           bytes_sent;
	int           frames_sent;
	int           cycles;
	int           src_idle;
	int           snk_idle;
	int           hold_requests;
	int           hold_served;
	int           hold_left;

	typedef struct {
		logic [7:0] fb;
		logic       lb;
		bit         typed;
		ev_kind_t   kind;
		logic [7:0] exc;
		err_code_t  err;
	} dir_row_t;

	// Rows assume the configuration after reset: slave 0, start address 0, one register.
	dir_row_t dir_tab [0:25] = '{
		'{8'h00, 1'b1, 1'b1, EV_ERROR, 8'h00, ERR_TRUNC},
		'{8'hFF, 1'b0, 1'b1, EV_ERROR, 8'h00, ERR_SLAVE},
		'{8'h55, 1'b1, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h03, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h02, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'hFF, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h5A, 1'b1, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h83, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'hFF, 1'b1, 1'b1, EV_EXC,   8'hFF, ERR_SLAVE},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h04, 1'b1, 1'b1, EV_ERROR, 8'h00, ERR_FUNC},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h03, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h04, 1'b1, 1'b1, EV_ERROR, 8'h00, ERR_COUNT},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h03, 1'b1, 1'b1, EV_ERROR, 8'h00, ERR_TRUNC},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h03, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h02, 1'b1, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h00, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h03, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h02, 1'b0, 1'b0, EV_START, 8'h00, ERR_SLAVE},
		'{8'h12, 1'b1, 1'b0, EV_START, 8'h00, ERR_SLAVE}
	};

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycles,
				expected_events.size());
			$display("modbus_read_holding_response_parser_unit verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatches < 40)
			$display("event %0d: %s is %h, expected %h", events_checked, what, got, want);
		mismatches++;
	endtask

	function automatic void push_event(input bit record, input ev_kind_t kind,
			input logic [15:0] addr, input logic [15:0] val, input logic [7:0] exc,
			input err_code_t err);
		result_t r;
		r.event_kind     = kind;
		r.reg_address    = addr;
		r.reg_value      = val;
		r.exception_code = exc;
		r.error_code     = err;
		r.run_last       = 1'b0;
		if (record)
			expected_events.push_back(r);
	endfunction

	function automatic void close_frame(input logic lb);
		ph         = lb ? PH_ADDR : PH_SKIP;
		high_valid = 1'b0;
	endfunction

	// Advances the parser model by one accepted byte and queues the events it causes
	// unless the caller supplies its own expectation.
	function automatic void predict_parse(input logic [7:0] fb, input logic lb,
			input bit record);
		int n_before;
		n_before = expected_events.size();
		if (ph != PH_SKIP)
			parsed_items++;
		case (ph)
			PH_ADDR: begin
				if (fb != cfg_slave) begin
					push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_SLAVE);
					close_frame(lb);
				end else if (lb) begin
					push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_TRUNC);
					close_frame(1'b1);
				end else begin
					ph = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (fb == FC_READ_HOLDING || fb == (FC_READ_HOLDING | EXC_FLAG)) begin
					if (lb) begin
						push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_TRUNC);
						close_frame(1'b1);
					end else begin
						ph = (fb == FC_READ_HOLDING) ? PH_COUNT : PH_EXC;
					end
				end else begin
					push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_FUNC);
					close_frame(lb);
				end
			end
			PH_COUNT: begin
				if (cfg_count == 0 || cfg_count > MAX_REGS || fb != {cfg_count, 1'b0}) begin
					push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_COUNT);
					close_frame(lb);
				end else begin
					push_event(record, EV_START, 16'h0, 16'h0, 8'h0, ERR_SLAVE);
					cur_addr   = cfg_start;
					regs_left  = cfg_count;
					high_valid = 1'b0;
					high_hold  = 8'h00;
					if (lb) begin
						push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_TRUNC);
						close_frame(1'b1);
					end else begin
						ph = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (!high_valid) begin
					high_hold  = fb;
					high_valid = 1'b1;
					if (lb) begin
						push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_TRUNC);
						close_frame(1'b1);
					end
				end else begin
					push_event(record, EV_VALUE, cur_addr, {high_hold, fb}, 8'h0, ERR_SLAVE);
					cur_addr   = cur_addr + 16'd1;
					regs_left  = regs_left - 7'd1;
					high_valid = 1'b0;
					if (regs_left == 0) begin
						push_event(record, EV_END, 16'h0, 16'h0, 8'h0, ERR_SLAVE);
						close_frame(lb);
					end else if (lb) begin
						push_event(record, EV_ERROR, 16'h0, 16'h0, 8'h0, ERR_TRUNC);
						close_frame(1'b1);
					end
				end
			end
			PH_EXC: begin
				push_event(record, EV_EXC, 16'h0, 16'h0, fb, ERR_SLAVE);
				close_frame(lb);
			end
			default: begin
				// Trailing bytes of a finished or failed frame are dropped up to the last one.
				if (lb)
					ph = PH_ADDR;
			end
		endcase
		if (expected_events.size() > n_before)
			expected_events[expected_events.size() - 1].run_last = 1'b1;
	endfunction

	// Offers one byte from the falling edge on and waits for its transfer.
	task automatic send_byte(input logic [7:0] fb, input logic lb, input bit record);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = fb;
		s_axis_tlast  = lb;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_parse(fb, lb, record);
		bytes_sent++;
	endtask

	task automatic write_cfg(input cfg_index_t idx, input logic [15:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_EXPECTED_SLAVE: cfg_slave = d[7:0];
			CFG_START_ADDRESS:  cfg_start = d;
			CFG_REGISTER_COUNT: cfg_count = d[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops offering bytes and waits until every queued event has been seen, then lets
	// a byte that caused no event work its way through the pipeline.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_frame();
		logic [7:0] fr [$];
		logic [7:0] bad;
		int         r;
		int         n_regs;
		int         cut;
		r = $urandom_range(99);
		fr.push_back(cfg_slave);
		if (r < 65 || (r >= 75 && r < 95)) begin
			fr.push_back(FC_READ_HOLDING);
			fr.push_back({cfg_count, 1'b0});
			// Keep frames short when the count can never match anyway.
			n_regs = (cfg_count > MAX_REGS) ? $urandom_range(2) : cfg_count;
			repeat (2 * n_regs) fr.push_back(8'($urandom_range(255)));
		end else if (r < 75) begin
			fr.push_back(FC_READ_HOLDING | EXC_FLAG);
			fr.push_back(8'($urandom_range(255)));
		end else begin
			fr.delete();
			repeat ($urandom_range(4, 1)) fr.push_back(8'($urandom_range(255)));
		end
		if (r >= 75 && r < 95) begin
			case ($urandom_range(3))
				0: fr[0] = cfg_slave ^ 8'($urandom_range(255, 1));
				1: begin
					do
						bad = 8'($urandom_range(255));
					while (bad == FC_READ_HOLDING || bad == (FC_READ_HOLDING | EXC_FLAG));
					fr[1] = bad;
				end
				2: fr[2] = fr[2] ^ 8'($urandom_range(255, 1));
				default: begin
					cut = $urandom_range(fr.size() - 1, 1);
					fr  = fr[0:cut-1];
				end
			endcase
		end else if (r < 75 && $urandom_range(99) < 15) begin
			repeat ($urandom_range(3, 1)) fr.push_back(8'($urandom_range(255)));
		end
		for (int i = 0; i < fr.size(); i++)
			send_byte(fr[i], i == fr.size() - 1, 1'b1);
		frames_sent++;
	endtask

	// Event checker: every transfer on the master stream against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected event kind", 16'(m_axis_tuser), 16'h0);
			end else begin
				want = expected_events.pop_front();
				if (m_axis_tuser !== want.event_kind)
					report_mismatch("event_kind", 16'(m_axis_tuser), 16'(want.event_kind));
				if (m_axis_tdata[15:0] !== want.reg_address)
					report_mismatch("reg_address", m_axis_tdata[15:0], want.reg_address);
				if (m_axis_tdata[31:16] !== want.reg_value)
					report_mismatch("reg_value", m_axis_tdata[31:16], want.reg_value);
				if (m_axis_tdata[39:32] !== want.exception_code)
					report_mismatch("exception_code", 16'(m_axis_tdata[39:32]),
						16'(want.exception_code));
				if (m_axis_tdata[41:40] !== want.error_code)
					report_mismatch("error_code", 16'(m_axis_tdata[41:40]),
						16'(want.error_code));
				if (m_axis_tdata[47:42] !== 6'h00)
					report_mismatch("tdata padding", 16'(m_axis_tdata[47:42]), 16'h0);
				if (m_axis_tlast !== want.run_last)
					report_mismatch("run_last", 16'(m_axis_tlast), 16'(want.run_last));
			end
			events_checked++;
		end
	end

	// Receiver: random back-pressure, plus long hold-offs on request so the unit fills up.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = ($urandom_range(99) >= snk_idle);
			end
		end
	end

	initial begin
		result_t        typed_event;
		logic [7:0]     slave_v;
		logic [15:0]    start_v;
		logic [15:0]    count_v;
		int             phase_base;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_EXPECTED_SLAVE;
		cfg_data      = 16'h0000;
		ph            = PH_ADDR;
		cur_addr      = 16'h0000;
		regs_left     = 7'd0;
		high_hold     = 8'h00;
		high_valid    = 1'b0;
		cfg_slave     = 8'h00;
		cfg_start     = 16'h0000;
		cfg_count     = 7'd1;
		mismatches    = 0;
		events_checked = 0;
		parsed_items  = 0;
		bytes_sent    = 0;
		frames_sent   = 0;
		cycles        = 0;
		src_idle      = 16;
		snk_idle      = 62;
		hold_requests = 0;
		hold_served   = 0;
		hold_left     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset configuration.
		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].fb, dir_tab[i].lb, !dir_tab[i].typed);
			if (dir_tab[i].typed) begin
				typed_event.event_kind     = dir_tab[i].kind;
				typed_event.reg_address    = 16'h0000;
				typed_event.reg_value      = 16'h0000;
				typed_event.exception_code = dir_tab[i].exc;
				typed_event.error_code     = dir_tab[i].err;
				typed_event.run_last       = 1'b1;
				expected_events.push_back(typed_event);
			end
		end
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			src_idle = (p < 4) ? 16 : (p < 8) ? 62 : 0;
			snk_idle = (p < 4) ? 62 : (p < 8) ? 16 : 0;
			slave_v  = 8'($urandom_range(255));
			start_v  = 16'($urandom_range(65535));
			count_v  = 16'($urandom_range(6, 1));
			// The first settings sweep the extremes, including counts that can never match.
			case (p)
				0: begin slave_v = 8'h00; start_v = 16'h0000; count_v = 16'd1; end
				1: begin slave_v = 8'hFF; start_v = 16'hFFFF; count_v = 16'd2; end
				2: begin start_v = 16'hFFF0; count_v = 16'd125; end
				3: begin count_v = 16'hFF80; end
				4: begin slave_v = 8'h80; start_v = 16'h8000; count_v = 16'h007F; end
				5: begin count_v = 16'd126; end
				default: ;
			endcase
			write_cfg(CFG_EXPECTED_SLAVE, {8'($urandom_range(255)), slave_v});
			write_cfg(CFG_START_ADDRESS, start_v);
			write_cfg(CFG_REGISTER_COUNT, count_v);
			if (p == 1 || p == 6 || p == 9)
				hold_requests++;
			phase_base = parsed_items;
			while (parsed_items - phase_base < PHASE_ITEMS)
				send_frame();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d bytes in %0d random frames plus the directed table, %0d parsed",
			bytes_sent, frames_sent, parsed_items);
		$display("%0d events checked over %0d register settings, %0d mismatches",
			events_checked, NUM_PHASES + 1, mismatches);
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("modbus_read_holding_response_parser_unit verification clean");
		end else begin
			$display("modbus_read_holding_response_parser_unit verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/mrhp_pkg.sv
sv/mrhp_core.sv
sv/modbus_read_holding_response_parser_unit.sv
bench/tb_top.sv
